// ----- rtl/lru_page_replacement_top_defines.svh -----
// Assertion macros for the LRU page replacement block.
// Used by the top level only; no other dependencies.
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lru_page_replacement: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lru_page_replacement: next-cycle check failed");

`endif

// ----- rtl/lrp_pkg.sv -----
// Shared types and constants of the LRU page replacement block.
// No dependencies; imported by lrp_lookup, lrp_frames and the top level.
`default_nettype none

package lrp_pkg;

    localparam int PAGE_W  = 16;  // page_number and evicted_page ports
    localparam int SLOT_W  = 3;   // frame_slot port
    localparam int CFG_W   = 4;   // frames_in_use register
    localparam int FAULT_W = 16;  // fault_total port

    localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd3;
    localparam logic [FAULT_W-1:0] FAULT_MAX    = 16'hFFFF;

    // Outcome of one lookup, passed from the lookup logic to the frame store.
    typedef struct packed {
        logic hit;    // page resident in an active frame
        logic evict;  // miss with no empty frame: victim replaced
    } t_lkp_flags;

endpackage

`default_nettype wire

// ----- rtl/lrp_lookup.sv -----
// Combinational lookup: tag match, first empty frame and LRU victim.
// Depends on lrp_pkg (t_lkp_flags).
`default_nettype none

module lrp_lookup
    import lrp_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int IW         = 3,
    parameter int CW         = 4
) (
    input  wire logic [PAGE_BITS-1:0] i_tag,
    input  wire logic [CW-1:0]        i_frames,
    input  wire logic [PAGE_BITS-1:0] i_frame_page [MAX_FRAMES],
    input  wire logic [MAX_FRAMES-1:0] i_frame_valid,
    input  wire logic [IW-1:0]        i_rank [MAX_FRAMES],
    output t_lkp_flags                o_flags,
    output logic [IW-1:0]             o_slot,
    output logic [PAGE_BITS-1:0]      o_evict_page
);

    logic [MAX_FRAMES-1:0] in_use;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [MAX_FRAMES-1:0] victim;
    logic [IW-1:0]         hit_idx;
    logic [IW-1:0]         empty_idx;
    logic [IW-1:0]         victim_idx;
    logic [PAGE_BITS-1:0]  victim_page;

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            in_use[i] = (CW'(i) < i_frames);
            match[i]  = in_use[i] && i_frame_valid[i] && (i_frame_page[i] == i_tag);
            empty[i]  = in_use[i] && !i_frame_valid[i];
        end
    end

    // Victim: the active frame whose rank is below every other active rank.
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            victim[i] = in_use[i];
            for (int j = 0; j < MAX_FRAMES; j++) begin
                if (j != i && in_use[j] && (i_rank[j] < i_rank[i])) begin
                    victim[i] = 1'b0;
                end
            end
        end
    end

    // Lowest index wins for matches and empty frames.
    always_comb begin
        hit_idx     = '0;
        empty_idx   = '0;
        victim_idx  = '0;
        victim_page = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (empty[i]) begin
                empty_idx = IW'(i);
            end
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (victim[i]) begin
                victim_idx  = victim_idx | IW'(i);
                victim_page = victim_page | i_frame_page[i];
            end
        end
    end

    always_comb begin
        o_flags.hit   = |match;
        o_flags.evict = !(|match) && !(|empty);
        if (o_flags.hit) begin
            o_slot = hit_idx;
        end else if (|empty) begin
            o_slot = empty_idx;
        end else begin
            o_slot = victim_idx;
        end
        o_evict_page = o_flags.evict ? victim_page : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/lrp_frames.sv -----
// Frame store: page tags, valid marks and recency ranks with LRU update.
// Depends on lrp_pkg (t_lkp_flags).
`default_nettype none

module lrp_frames
    import lrp_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int IW         = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_update,
    input  wire logic                  i_clear,
    input  wire logic [PAGE_BITS-1:0]  i_tag,
    input  wire t_lkp_flags            i_flags,
    input  wire logic [IW-1:0]         i_slot,
    output logic [PAGE_BITS-1:0]       o_frame_page [MAX_FRAMES],
    output logic [MAX_FRAMES-1:0]      o_frame_valid,
    output logic [IW-1:0]              o_rank [MAX_FRAMES]
);

    localparam logic [IW-1:0] RANK_NEWEST = IW'(MAX_FRAMES - 1);

    logic [PAGE_BITS-1:0]  r_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [IW-1:0]         r_rank [MAX_FRAMES];
    logic [IW-1:0]         n_rank [MAX_FRAMES];
    logic [IW-1:0]         old_rank;

    // Move the used frame to newest; close the gap above its old rank.
    always_comb begin
        old_rank = r_rank[i_slot];
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (IW'(i) == i_slot) begin
                n_rank[i] = RANK_NEWEST;
            end else if (r_rank[i] > old_rank) begin
                n_rank[i] = r_rank[i] - IW'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= IW'(i);
            end
        end else if (i_update) begin
            if (i_clear) begin
                r_valid <= '0;
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    r_rank[i] <= IW'(i);
                end
            end else begin
                r_rank <= n_rank;
                if (!i_flags.hit) begin
                    r_valid[i_slot] <= 1'b1;
                end
            end
        end
    end

    // Tags carry no reset; they are only read behind a valid mark.
    always_ff @(posedge i_clk) begin
        if (i_update && !i_flags.hit) begin
            r_page[i_slot] <= i_tag;
        end
    end

    assign o_frame_page  = r_page;
    assign o_frame_valid = r_valid;
    assign o_rank        = r_rank;

endmodule

`default_nettype wire

// ----- rtl/lru_page_replacement_top.sv -----
// Top level of the LRU page replacement block: input register, lookup, result register.
// Depends on lrp_pkg, lrp_lookup, lrp_frames and lru_page_replacement_top_defines.svh.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+-------------------------------------
//   in       | to block  | i_in_valid / o_in_stall      | i_page_number, i_last_access
//   out      | from block| o_out_valid / i_out_stall    | o_hit, o_frame_slot, o_evicted_valid,
//            |           |                              | o_evicted_page, o_fault_total
//   cfg      | to block  | i_cfg_valid / o_cfg_ready    | i_cfg_data (frames_in_use)
//
// Input and result registers; one transaction per cycle while i_out_stall is low.
// The combinational path is the tag compare plus rank update between the input and
// result registers, and the frame state is updated on the same edge as the result.
// Reset is synchronous: frames empty, ranks equal frame index, fault count zero,
// frames_in_use = 3. A stall on the output backs up into the input register and then
// into o_in_stall in the same cycle; no transaction is dropped.
`default_nettype none

`include "lru_page_replacement_top_defines.svh"

module lru_page_replacement_top
    import lrp_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input transactions
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [PAGE_W-1:0]  i_page_number,
    input  wire logic               i_last_access,
    // result transactions
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_hit,
    output logic [SLOT_W-1:0]       o_frame_slot,
    output logic                    o_evicted_valid,
    output logic [PAGE_W-1:0]       o_evicted_page,
    output logic [FAULT_W-1:0]      o_fault_total,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    localparam int IW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

    // Configuration register and the clamped active frame count.
    logic [CFG_W-1:0] r_frames_cfg;
    logic [CW-1:0]    active_frames;

    // Input register.
    logic                 r_s1_valid;
    logic [PAGE_BITS-1:0] r_s1_tag;
    logic                 r_s1_last;

    // Result register.
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_evict;
    logic [PAGE_W-1:0]    r_out_evict_page;
    logic [FAULT_W-1:0]   r_out_fault;

    logic [FAULT_W-1:0]   r_fault;
    logic [FAULT_W-1:0]   n_fault;

    logic in_accept;
    logic out_accept;
    logic s1_adv;

    logic [PAGE_BITS-1:0]  frame_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] frame_valid;
    logic [IW-1:0]         frame_rank [MAX_FRAMES];
    t_lkp_flags            lkp_flags;
    logic [IW-1:0]         lkp_slot;
    logic [PAGE_BITS-1:0]  lkp_evict_page;

    // Handshakes: the input register moves on when the result register is free
    // or is being emptied in this cycle.
    assign out_accept  = r_out_valid && !i_out_stall;
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Clamp the frame count: zero acts as one, anything above the array size as all.
    always_comb begin
        if (r_frames_cfg == '0) begin
            active_frames = CW'(1);
        end else if (CMP_W'(r_frames_cfg) > CMP_W'(MAX_FRAMES)) begin
            active_frames = CW'(MAX_FRAMES);
        end else begin
            active_frames = CW'(r_frames_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= FRAMES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frames_cfg <= i_cfg_data;
        end
    end

    // Input register: hold while blocked, load on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_tag  <= PAGE_BITS'(i_page_number);
            r_s1_last <= i_last_access;
        end
    end

    lrp_lookup #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IW         (IW),
        .CW         (CW)
    ) u_lookup (
        .i_tag         (r_s1_tag),
        .i_frames      (active_frames),
        .i_frame_page  (frame_page),
        .i_frame_valid (frame_valid),
        .i_rank        (frame_rank),
        .o_flags       (lkp_flags),
        .o_slot        (lkp_slot),
        .o_evict_page  (lkp_evict_page)
    );

    // Frame state advances on the same edge that the result is registered;
    // a last-access transaction wipes it instead.
    lrp_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IW         (IW)
    ) u_frames (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_update      (s1_adv),
        .i_clear       (r_s1_last),
        .i_tag         (r_s1_tag),
        .i_flags       (lkp_flags),
        .i_slot        (lkp_slot),
        .o_frame_page  (frame_page),
        .o_frame_valid (frame_valid),
        .o_rank        (frame_rank)
    );

    // Fault count: bump on a miss, saturate at full scale.
    always_comb begin
        if (lkp_flags.hit || r_fault == FAULT_MAX) begin
            n_fault = r_fault;
        end else begin
            n_fault = r_fault + FAULT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (s1_adv) begin
            r_fault <= r_s1_last ? '0 : n_fault;
        end
    end

    // Result register: load when the input register advances, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_hit        <= lkp_flags.hit;
            r_out_slot       <= SLOT_W'(lkp_slot);
            r_out_evict      <= lkp_flags.evict;
            r_out_evict_page <= PAGE_W'(lkp_evict_page);
            r_out_fault      <= n_fault;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_slot    = r_out_slot;
    assign o_evicted_valid = r_out_evict;
    assign o_evicted_page  = r_out_evict_page;
    assign o_fault_total   = r_out_fault;

    // An eviction only ever comes with a miss.
    `LRP_ASSERT_SAME(a_evict_on_miss, i_clk, i_rst_n, r_out_valid && r_out_evict, !r_out_hit)

    // A last-access transaction leaves the fault count cleared.
    `LRP_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, s1_adv && r_s1_last, r_fault == '0)

    // Within a reference string the fault count never falls.
    `LRP_ASSERT_NEXT(a_fault_monotonic, i_clk, i_rst_n, s1_adv && !r_s1_last, r_fault >= $past(r_fault))

endmodule

`default_nettype wire
